@@ rtl/jsplit_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON array splitter package
// Shared constants, status codes and structures of the array splitter.
// ----------------------------------------------------------------------------
package jsplit_pkg;

    // Default sizes of the nesting stack and of the body offset counter.
    localparam int MAX_NESTING_DEF = 32;
    localparam int BODY_BYTES_DEF  = 65536;

    // Width of the nesting limit register.
    localparam int LIMIT_W = 6;

    // Register map (byte addresses).
    localparam int  PADDR_W        = 3;
    localparam int  REG_IDX_LIMIT  = 0;

    // Byte codes the scanner reacts to.
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // Final status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNEXPECTED = 3'd1;
    localparam logic [2:0] ST_MISMATCH   = 3'd2;
    localparam logic [2:0] ST_TOO_DEEP   = 3'd3;
    localparam logic [2:0] ST_UNTERM     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG   = 3'd5;

    // Operation on the nesting stack for one item.
    typedef struct packed {
        logic push;
        logic pop;
        logic push_brace;
    } stack_op_t;

    // One result item.
    typedef struct packed {
        logic        object_valid;
        logic [15:0] object_start;
        logic [15:0] object_length;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] object_count;
    } result_t;

endpackage

@@ rtl/jsplit_cfg.sv @@
// ----------------------------------------------------------------------------
// JSON array splitter configuration registers
// APB-style register file holding the nesting limit.
// ----------------------------------------------------------------------------
module jsplit_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jsplit_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [jsplit_pkg::LIMIT_W-1:0]    nesting_limit
);

    logic [jsplit_pkg::LIMIT_W-1:0] limit_reg;
    logic                           sel_limit;

    // Registers are word aligned; the word index selects the register.
    assign sel_limit = (paddr[jsplit_pkg::PADDR_W-1:2]
                        == 1'(jsplit_pkg::REG_IDX_LIMIT));
    assign pready    = 1'b1;

    // Write on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 6'd32;
        end else if (psel && penable && pwrite && pready && sel_limit) begin
            limit_reg <= pwdata[jsplit_pkg::LIMIT_W-1:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = 32'd0;
        if (sel_limit) begin
            prdata = {{(32 - jsplit_pkg::LIMIT_W){1'b0}}, limit_reg};
        end
    end

    assign nesting_limit = limit_reg;

endmodule

@@ rtl/jsplit_stack.sv @@
// ----------------------------------------------------------------------------
// JSON array splitter nesting stack
// Shift-register stack of open braces (1) and brackets (0), top at bit 0.
// ----------------------------------------------------------------------------
module jsplit_stack #(
    parameter int MAX_NESTING = jsplit_pkg::MAX_NESTING_DEF
) (
    input  logic                  aclk,
    input  jsplit_pkg::stack_op_t op,
    output logic                  top_brace
);

    logic [MAX_NESTING-1:0] stack_reg;
    logic [MAX_NESTING-1:0] stack_next;

    // Push shifts toward the bottom, pop shifts toward the top.
    generate
        if (MAX_NESTING == 1) begin : g_single
            always_comb begin
                stack_next = stack_reg;
                if (op.push) begin
                    stack_next = op.push_brace;
                end
            end
        end else begin : g_multi
            always_comb begin
                stack_next = stack_reg;
                if (op.push) begin
                    stack_next = {stack_reg[MAX_NESTING-2:0], op.push_brace};
                end else if (op.pop) begin
                    stack_next = {1'b0, stack_reg[MAX_NESTING-1:1]};
                end
            end
        end
    endgenerate

    // Contents only matter below the current depth, so no reset is needed.
    always_ff @(posedge aclk) begin
        stack_reg <= stack_next;
    end

    assign top_brace = stack_reg[0];

endmodule

@@ rtl/jsplit_scan.sv @@
// ----------------------------------------------------------------------------
// JSON array splitter byte scanner
// Per-byte state machine: phases, strings, nesting depth, offsets and errors.
// ----------------------------------------------------------------------------
module jsplit_scan #(
    parameter int MAX_NESTING = jsplit_pkg::MAX_NESTING_DEF,
    parameter int BODY_BYTES  = jsplit_pkg::BODY_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    input  logic [7:0]                     data_byte,
    input  logic                           byte_present,
    input  logic                           last_byte,
    input  logic [jsplit_pkg::LIMIT_W-1:0] nesting_limit,
    input  logic                           top_brace,
    output jsplit_pkg::stack_op_t          stack_op,
    output logic                           res_valid,
    output jsplit_pkg::result_t            res
);

    localparam int DW   = $clog2(MAX_NESTING + 1);
    localparam int OW   = $clog2(BODY_BYTES + 1);
    localparam int CMPW = (DW > jsplit_pkg::LIMIT_W) ? DW : jsplit_pkg::LIMIT_W;

    // Phase codes.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_OBJECT = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;
    localparam logic [1:0] PH_COMMA  = 2'd3;

    logic [1:0]    phase_reg,  phase_next;
    logic          str_reg,    str_next;
    logic          esc_reg,    esc_next;
    logic [DW-1:0] depth_reg,  depth_next;
    logic [OW-1:0] off_reg,    off_next;
    logic [OW-1:0] start_reg,  start_next;
    logic [15:0]   count_reg,  count_next;
    logic [2:0]    err_reg,    err_next;

    logic                           is_space;
    logic                           beyond;
    logic                           closed;
    logic                           too_deep;
    logic [jsplit_pkg::LIMIT_W-1:0] lim_eff;
    logic [31:0]                    len32;
    logic [31:0]                    start32;
    logic [2:0]                     final_status;
    jsplit_pkg::stack_op_t          op;

    assign is_space = (data_byte == jsplit_pkg::CH_SPACE) ||
                      ((data_byte >= jsplit_pkg::CH_TAB) && (data_byte <= jsplit_pkg::CH_CR));
    assign beyond   = (off_reg >= OW'(BODY_BYTES));
    assign lim_eff  = (nesting_limit == '0) ? jsplit_pkg::LIMIT_W'(1) : nesting_limit;
    assign too_deep = (CMPW'(depth_reg) >= CMPW'(lim_eff)) ||
                      (depth_reg >= DW'(MAX_NESTING));
    assign start32  = 32'(start_reg);
    assign len32    = 32'(off_reg) - start32 + 32'd1;

    // Next state for one byte.
    always_comb begin
        phase_next   = phase_reg;
        str_next     = str_reg;
        esc_next     = esc_reg;
        depth_next   = depth_reg;
        off_next     = off_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        closed       = 1'b0;
        op           = '0;
        final_status = jsplit_pkg::ST_OK;

        if (byte_present) begin
            if (beyond) begin
                if (err_reg == jsplit_pkg::ST_OK) begin
                    err_next = jsplit_pkg::ST_TOO_LONG;
                end
            end else if (err_reg == jsplit_pkg::ST_OK) begin
                unique case (phase_reg)
                    PH_FIRST, PH_COMMA: begin
                        if (is_space) begin
                            phase_next = phase_reg;
                        end else if (data_byte == jsplit_pkg::CH_LBRACE) begin
                            start_next    = off_reg;
                            depth_next    = DW'(1);
                            str_next      = 1'b0;
                            esc_next      = 1'b0;
                            phase_next    = PH_OBJECT;
                            op.push       = 1'b1;
                            op.push_brace = 1'b1;
                        end else begin
                            err_next = jsplit_pkg::ST_UNEXPECTED;
                        end
                    end
                    PH_AFTER: begin
                        if (is_space) begin
                            phase_next = phase_reg;
                        end else if (data_byte == jsplit_pkg::CH_COMMA) begin
                            phase_next = PH_COMMA;
                        end else begin
                            err_next = jsplit_pkg::ST_UNEXPECTED;
                        end
                    end
                    PH_OBJECT: begin
                        if (str_reg) begin
                            // Inside a string only escapes and the closing quote matter.
                            if (esc_reg) begin
                                esc_next = 1'b0;
                            end else if (data_byte == jsplit_pkg::CH_BSLASH) begin
                                esc_next = 1'b1;
                            end else if (data_byte == jsplit_pkg::CH_QUOTE) begin
                                str_next = 1'b0;
                            end
                        end else if (data_byte == jsplit_pkg::CH_QUOTE) begin
                            str_next = 1'b1;
                        end else if ((data_byte == jsplit_pkg::CH_LBRACE) ||
                                     (data_byte == jsplit_pkg::CH_LBRACKET)) begin
                            if (too_deep) begin
                                err_next = jsplit_pkg::ST_TOO_DEEP;
                            end else begin
                                op.push       = 1'b1;
                                op.push_brace = (data_byte == jsplit_pkg::CH_LBRACE);
                                depth_next    = depth_reg + 1'b1;
                            end
                        end else if ((data_byte == jsplit_pkg::CH_RBRACE) ||
                                     (data_byte == jsplit_pkg::CH_RBRACKET)) begin
                            if ((depth_reg == '0) ||
                                (top_brace != (data_byte == jsplit_pkg::CH_RBRACE))) begin
                                err_next = jsplit_pkg::ST_MISMATCH;
                            end else begin
                                op.pop     = 1'b1;
                                depth_next = depth_reg - 1'b1;
                                if (depth_reg == DW'(1)) begin
                                    phase_next = PH_AFTER;
                                    closed     = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
            if (!beyond) begin
                off_next = off_reg + 1'b1;
            end
        end

        if (closed && (count_reg != 16'hFFFF)) begin
            count_next = count_reg + 16'd1;
        end

        // Final status uses the state as left by this byte.
        final_status = err_next;
        if ((err_next == jsplit_pkg::ST_OK) &&
            ((phase_next == PH_OBJECT) || (phase_next == PH_COMMA))) begin
            final_status = jsplit_pkg::ST_UNTERM;
        end

        // Result item.
        res_valid         = closed || last_byte;
        res.object_valid  = closed;
        res.object_start  = closed ? start32[15:0] : 16'd0;
        res.object_length = closed ? ((len32 > 32'h0000_FFFF) ? 16'hFFFF : len32[15:0])
                                   : 16'd0;
        res.done_res      = last_byte;
        res.status        = last_byte ? final_status : jsplit_pkg::ST_OK;
        res.object_count  = last_byte ? count_next : 16'd0;

        // End of body returns everything to the start state.
        if (last_byte) begin
            phase_next = PH_FIRST;
            str_next   = 1'b0;
            esc_next   = 1'b0;
            depth_next = '0;
            off_next   = '0;
            start_next = '0;
            count_next = '0;
            err_next   = jsplit_pkg::ST_OK;
        end
    end

    // The stack moves only on an item that is really processed.
    always_comb begin
        stack_op            = op;
        stack_op.push       = op.push && item_valid;
        stack_op.pop        = op.pop && item_valid;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            depth_reg <= '0;
            off_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            err_reg   <= jsplit_pkg::ST_OK;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
            depth_reg <= depth_next;
            off_reg   <= off_next;
            start_reg <= start_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ rtl/json_object_array_splitter.sv @@
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the input register, scanner and result
// register form a two-stage pipeline that advances whenever the result
// register is empty or being taken.
// Reset: synchronous, active low; clears all body state and sets the
// nesting limit to 32. The stack contents need no reset.
// ----------------------------------------------------------------------------
// JSON array object splitter
// Splits a JSON array body, one byte per item, into its top-level objects.
// ----------------------------------------------------------------------------
module json_object_array_splitter #(
    parameter int MAX_NESTING = jsplit_pkg::MAX_NESTING_DEF,
    parameter int BODY_BYTES  = jsplit_pkg::BODY_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] byte_present
    input  logic                           s_tlast,   // last_byte
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] object_start, [31:16] object_length, [34:32] status,
    // [50:35] object_count, [55:51] zero
    output logic [55:0]                    m_tdata,
    output logic                           m_tuser,   // [0] object_valid
    output logic                           m_tlast,   // done_res
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jsplit_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic                           in_valid_reg;
    logic [7:0]                     in_byte_reg;
    logic                           in_present_reg;
    logic                           in_last_reg;
    logic                           m_valid_reg;
    jsplit_pkg::result_t            m_res_reg;
    logic                           out_ready;
    logic                           adv;
    logic                           res_valid;
    jsplit_pkg::result_t            res;
    jsplit_pkg::stack_op_t          stack_op;
    logic                           top_brace;
    logic [jsplit_pkg::LIMIT_W-1:0] nesting_limit;

    jsplit_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .nesting_limit (nesting_limit)
    );

    jsplit_stack #(
        .MAX_NESTING (MAX_NESTING)
    ) u_stack (
        .aclk      (aclk),
        .op        (stack_op),
        .top_brace (top_brace)
    );

    jsplit_scan #(
        .MAX_NESTING (MAX_NESTING),
        .BODY_BYTES  (BODY_BYTES)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (adv),
        .data_byte     (in_byte_reg),
        .byte_present  (in_present_reg),
        .last_byte     (in_last_reg),
        .nesting_limit (nesting_limit),
        .top_brace     (top_brace),
        .stack_op      (stack_op),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Pipeline control.
    assign out_ready = !m_valid_reg || m_tready;
    assign adv       = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.object_count, m_res_reg.status,
                       m_res_reg.object_length, m_res_reg.object_start};
    assign m_tuser  = m_res_reg.object_valid;
    assign m_tlast  = m_res_reg.done_res;

endmodule
